// ----- sv/imu_frame_deframer_scaler_top_assert.svh -----
// Assertion macros for the IMU frame deframer and scaler.
// Included by the top level; no other dependencies.
`ifndef IMU_FRAME_DEFRAMER_SCALER_TOP_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_SCALER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IMU_FDS_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("imu_fds assertion failed");
`define IMU_FDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("imu_fds assertion failed");
`else
`define IMU_FDS_ASSERT(lbl, clk, rstn, ante, cons)
`define IMU_FDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/imu_fds_pkg.sv -----
// Types and constants for the IMU frame deframer and scaler.
// No dependencies.
package imu_fds_pkg;

	localparam int GainWidth  = 20;
	localparam int ValueWidth = 21;
	localparam int AxisBytes  = 6;

	localparam logic [GainWidth-1:0] AccelGainRst = 20'd40141;
	localparam logic [GainWidth-1:0] RateGainRst  = 20'd512000;
	localparam logic [GainWidth-1:0] AngleGainRst = 20'd46080;

	localparam logic [7:0] HdrByte = 8'h55;
	localparam logic [7:0] TypeLo  = 8'h51;
	localparam logic [7:0] TypeHi  = 8'h54;

	localparam logic [3:0] PosHunt      = 4'd0;
	localparam logic [3:0] PosType      = 4'd1;
	localparam logic [3:0] PosFirstData = 4'd2;
	localparam logic [3:0] PosSum       = 4'd10;

	typedef enum logic [1:0] {
		KIND_ACCEL,
		KIND_RATE,
		KIND_ANGLE,
		KIND_MAG
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_BAD_TYPE,
		STATUS_BAD_SUM
	} status_t;

	typedef enum logic [1:0] {
		REG_ACCEL_GAIN,
		REG_RATE_GAIN,
		REG_ANGLE_GAIN
	} cfg_reg_t;

endpackage

// ----- sv/imu_frame_deframer_scaler_top.sv -----
// IMU serial frame deframer and scaler: top level.
// Depends on imu_fds_pkg and imu_frame_deframer_scaler_top_assert.svh.
`include "imu_frame_deframer_scaler_top_assert.svh"

// Takes one received byte per beat at up to one beat per cycle and hunts for
// eleven-byte frames that open with 0x55, reporting a bad type byte or a bad
// checksum as a result of its own and otherwise three axis values scaled to
// Q.8 by the gain register of the frame type, except for magnetic frames, whose
// raw values are passed sign-extended. A byte is registered on acceptance and
// processed from that register; the result register is loaded when the stage
// advances on the completing byte. The rate is set by the single processing
// stage, which holds its byte only when it must emit a result while the result
// register is occupied and not being read in the same cycle.
module imu_frame_deframer_scaler_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [imu_fds_pkg::GainWidth-1:0]   cfg_data,
	input  logic                                rx_valid,
	output logic                                rx_ready,
	input  logic [7:0]                          rx_byte,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [1:0]                          frame_kind,
	output logic [1:0]                          status,
	output logic signed [imu_fds_pkg::ValueWidth-1:0] x_value,
	output logic signed [imu_fds_pkg::ValueWidth-1:0] y_value,
	output logic signed [imu_fds_pkg::ValueWidth-1:0] z_value
);
	import imu_fds_pkg::*;

	logic [GainWidth-1:0] accel_gain_q;
	logic [GainWidth-1:0] rate_gain_q;
	logic [GainWidth-1:0] angle_gain_q;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	logic [3:0] byte_pos_q;
	logic [7:0] sum_q;
	kind_t      kind_q;
	logic [7:0] axis_byte_q [AxisBytes];

	logic                         res_valid_q;
	kind_t                        kind_res_q;
	status_t                      status_res_q;
	logic signed [ValueWidth-1:0] x_res_q;
	logic signed [ValueWidth-1:0] y_res_q;
	logic signed [ValueWidth-1:0] z_res_q;

	logic       emit;
	logic       adv_s1;
	logic       pay_we;
	logic [3:0] pos_d;
	logic [7:0] sum_d;
	kind_t      kind_d;
	kind_t      kind_out;
	status_t    status_out;
	logic [7:0] type_off;
	logic [3:0] data_off;

	logic [GainWidth-1:0]         gain;
	logic signed [GainWidth:0]    gain_s;
	logic signed [15:0]           raw_x;
	logic signed [15:0]           raw_y;
	logic signed [15:0]           raw_z;
	logic signed [36:0]           prod_x;
	logic signed [36:0]           prod_y;
	logic signed [36:0]           prod_z;
	logic signed [ValueWidth-1:0] x_out;
	logic signed [ValueWidth-1:0] y_out;
	logic signed [ValueWidth-1:0] z_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q <= AccelGainRst;
			rate_gain_q  <= RateGainRst;
			angle_gain_q <= AngleGainRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACCEL_GAIN: accel_gain_q <= cfg_data;
				REG_RATE_GAIN:  rate_gain_q  <= cfg_data;
				REG_ANGLE_GAIN: angle_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_d      = byte_pos_q;
		sum_d      = sum_q;
		kind_d     = kind_q;
		kind_out   = kind_q;
		status_out = STATUS_OK;
		emit       = 1'b0;
		pay_we     = 1'b0;
		type_off   = rx_byte_s1 - TypeLo;
		data_off   = byte_pos_q - PosFirstData;
		if (byte_pos_q == PosHunt || byte_pos_q > PosSum) begin
			pos_d = PosHunt;
			if (rx_byte_s1 == HdrByte) begin
				sum_d = rx_byte_s1;
				pos_d = PosType;
			end
		end else if (byte_pos_q == PosType) begin
			if (rx_byte_s1 < TypeLo || rx_byte_s1 > TypeHi) begin
				pos_d      = PosHunt;
				emit       = 1'b1;
				status_out = STATUS_BAD_TYPE;
				kind_out   = KIND_ACCEL;
			end else begin
				kind_d = kind_t'(type_off[1:0]);
				sum_d  = sum_q + rx_byte_s1;
				pos_d  = PosFirstData;
			end
		end else if (byte_pos_q < PosSum) begin
			sum_d  = sum_q + rx_byte_s1;
			pos_d  = byte_pos_q + 4'd1;
			pay_we = (data_off < 4'(AxisBytes));
		end else begin
			pos_d = PosHunt;
			emit  = 1'b1;
			if (sum_q != rx_byte_s1) begin
				status_out = STATUS_BAD_SUM;
			end
		end
	end

	always_comb begin
		case (kind_q)
			KIND_ACCEL: gain = accel_gain_q;
			KIND_RATE:  gain = rate_gain_q;
			default:    gain = angle_gain_q;
		endcase
	end

	assign gain_s = {1'b0, gain};
	assign raw_x  = {axis_byte_q[1], axis_byte_q[0]};
	assign raw_y  = {axis_byte_q[3], axis_byte_q[2]};
	assign raw_z  = {axis_byte_q[5], axis_byte_q[4]};
	assign prod_x = raw_x * gain_s;
	assign prod_y = raw_y * gain_s;
	assign prod_z = raw_z * gain_s;

	always_comb begin
		x_out = '0;
		y_out = '0;
		z_out = '0;
		if (status_out == STATUS_OK) begin
			if (kind_q == KIND_MAG) begin
				x_out = {{(ValueWidth-16){raw_x[15]}}, raw_x};
				y_out = {{(ValueWidth-16){raw_y[15]}}, raw_y};
				z_out = {{(ValueWidth-16){raw_z[15]}}, raw_z};
			end else begin
				x_out = prod_x[35:15];
				y_out = prod_y[35:15];
				z_out = prod_z[35:15];
			end
		end
	end

	assign adv_s1   = valid_s1 && (!emit || !res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= PosHunt;
			sum_q      <= '0;
			kind_q     <= KIND_ACCEL;
		end else if (adv_s1) begin
			byte_pos_q <= pos_d;
			sum_q      <= sum_d;
			kind_q     <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pay_we) begin
			axis_byte_q[data_off[2:0]] <= rx_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			kind_res_q   <= kind_out;
			status_res_q <= status_out;
			x_res_q      <= x_out;
			y_res_q      <= y_out;
			z_res_q      <= z_out;
		end
	end

	assign res_valid  = res_valid_q;
	assign frame_kind = kind_res_q;
	assign status     = status_res_q;
	assign x_value    = x_res_q;
	assign y_value    = y_res_q;
	assign z_value    = z_res_q;

	`IMU_FDS_ASSERT(a_pos_range, clk, arst_n, 1'b1, byte_pos_q <= PosSum)
	`IMU_FDS_ASSERT(a_stall_cause, clk, arst_n, !rx_ready, valid_s1 && res_valid_q && emit)
	`IMU_FDS_ASSERT_NEXT(a_frame_end_hunts, clk, arst_n, adv_s1 && emit, byte_pos_q == PosHunt)
	`IMU_FDS_ASSERT(a_bad_type_zero, clk, arst_n, res_valid_q && status_res_q == STATUS_BAD_TYPE,
		kind_res_q == KIND_ACCEL && x_res_q == '0 && y_res_q == '0 && z_res_q == '0)

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the IMU frame deframer and scaler: byte stream in, frame results out.
// Drives directed and random byte sequences, idling at random except in the last two phases,
// and checks every result against a predictor kept here. Depends on imu_fds_pkg and imu_frame_deframer_scaler_top.
module testbench;
	import imu_fds_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		status_t               stat;
		logic [ValueWidth-1:0] x;
		logic [ValueWidth-1:0] y;
		logic [ValueWidth-1:0] z;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	localparam logic [1:0] RegSpare = 2'd3;
	localparam int DirRows = 27;
	localparam int PhaseBeats = 200;
	localparam int WatchdogLimit = 2000;

	localparam frame_result_t NoResult = '{KIND_ACCEL, STATUS_OK, 21'd0, 21'd0, 21'd0};
	localparam frame_result_t BadTypeResult =
		'{KIND_ACCEL, STATUS_BAD_TYPE, 21'd0, 21'd0, 21'd0};
	localparam frame_result_t BadSumAccel = '{KIND_ACCEL, STATUS_BAD_SUM, 21'd0, 21'd0, 21'd0};
	localparam frame_result_t MagExtremes =
		'{KIND_MAG, STATUS_OK, 21'h1F8000, 21'h007FFF, 21'h000001};

	// Noise, a type byte either side of the valid range, a magnetic frame with
	// extreme axis values and an acceleration frame with a wrong checksum.
	stim_row_t directed_rows [DirRows] = '{
		'{8'h00, 1'b0, NoResult},
		'{8'h55, 1'b0, NoResult},
		'{8'h50, 1'b1, BadTypeResult},
		'{8'h55, 1'b0, NoResult},
		'{8'h55, 1'b1, BadTypeResult},
		'{8'h55, 1'b0, NoResult},
		'{8'h54, 1'b0, NoResult},
		'{8'h00, 1'b0, NoResult},
		'{8'h80, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'h7F, 1'b0, NoResult},
		'{8'h01, 1'b0, NoResult},
		'{8'h00, 1'b0, NoResult},
		'{8'h00, 1'b0, NoResult},
		'{8'h00, 1'b0, NoResult},
		'{8'hA8, 1'b1, MagExtremes},
		'{8'h55, 1'b0, NoResult},
		'{8'h51, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'hFF, 1'b0, NoResult},
		'{8'h9F, 1'b1, BadSumAccel}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [GainWidth-1:0]  cfg_data;
	logic                  rx_valid;
	logic                  rx_ready;
	logic [7:0]            rx_byte;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic [1:0]            frame_kind;
	logic [1:0]            status;
	logic signed [ValueWidth-1:0] x_value;
	logic signed [ValueWidth-1:0] y_value;
	logic signed [ValueWidth-1:0] z_value;

	imu_frame_deframer_scaler_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.frame_kind (frame_kind),
		.status     (status),
		.x_value    (x_value),
		.y_value    (y_value),
		.z_value    (z_value)
	);

	logic [GainWidth-1:0] accel_gain_m = AccelGainRst;
	logic [GainWidth-1:0] rate_gain_m  = RateGainRst;
	logic [GainWidth-1:0] angle_gain_m = AngleGainRst;
	logic [3:0]           frame_pos = PosHunt;
	logic [7:0]           frame_sum = 8'd0;
	kind_t                frame_kind_m = KIND_ACCEL;
	logic [7:0]           frame_data [8];

	frame_result_t frame_results_q [$];
	int errors = 0;
	int rx_beats = 0;
	int ok_frames = 0;
	int bad_type_count = 0;
	int bad_sum_count = 0;
	int send_idle = 33;
	int recv_idle = 54;
	int stall_cycles = 0;

	always #6 clk = ~clk;

	function automatic bit decode_byte(input logic [7:0] b, output frame_result_t r);
		logic [7:0]            d;
		logic signed [15:0]    raw;
		longint                prod;
		logic [GainWidth-1:0]  g;
		logic [ValueWidth-1:0] vals [3];
		r = '0;
		if (frame_pos == PosHunt) begin
			if (b == HdrByte) begin
				frame_sum = b;
				frame_pos = PosType;
			end
			return 1'b0;
		end
		if (frame_pos == PosType) begin
			if (b < TypeLo || b > TypeHi) begin
				frame_pos = PosHunt;
				r.stat = STATUS_BAD_TYPE;
				return 1'b1;
			end
			d = b - TypeLo;
			frame_kind_m = kind_t'(d[1:0]);
			frame_sum += b;
			frame_pos = PosFirstData;
			return 1'b0;
		end
		if (frame_pos < PosSum) begin
			frame_data[3'(frame_pos - PosFirstData)] = b;
			frame_sum += b;
			frame_pos += 4'd1;
			return 1'b0;
		end
		frame_pos = PosHunt;
		r.kind = frame_kind_m;
		if (frame_sum != b) begin
			r.stat = STATUS_BAD_SUM;
			return 1'b1;
		end
		case (frame_kind_m)
			KIND_ACCEL: g = accel_gain_m;
			KIND_RATE:  g = rate_gain_m;
			default:    g = angle_gain_m;
		endcase
		for (int i = 0; i < 3; i++) begin
			raw = {frame_data[2 * i + 1], frame_data[2 * i]};
			if (frame_kind_m == KIND_MAG) begin
				vals[i] = {{(ValueWidth - 16){raw[15]}}, raw};
			end else begin
				prod = longint'(raw) * longint'(g);
				prod = prod >>> 15;
				vals[i] = prod[ValueWidth-1:0];
			end
		end
		r.x = vals[0];
		r.y = vals[1];
		r.z = vals[2];
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t want);
		frame_result_t r;
		int gap;
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			rx_valid <= 1'b0;
		end
		@(negedge clk);
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		rx_beats++;
		if (decode_byte(b, r))
			frame_results_q.push_back(typed ? want : r);
	endtask

	task automatic settle();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (frame_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [GainWidth-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_ACCEL_GAIN: accel_gain_m = value;
			REG_RATE_GAIN:  rate_gain_m  = value;
			REG_ANGLE_GAIN: angle_gain_m = value;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [ValueWidth-1:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin : result_monitor
		frame_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (frame_results_q.size() == 0) begin
				$display("%0t: unexpected result beat, kind %0d status %0d", $time,
					frame_kind, status);
				errors++;
			end else begin
				want = frame_results_q.pop_front();
				check_field("frame_kind", ValueWidth'(want.kind), ValueWidth'(frame_kind));
				check_field("status", ValueWidth'(want.stat), ValueWidth'(status));
				check_field("x_value", want.x, x_value);
				check_field("y_value", want.y, y_value);
				check_field("z_value", want.z, z_value);
			end
			case (status)
				STATUS_OK:       ok_frames++;
				STATUS_BAD_TYPE: bad_type_count++;
				default:         bad_sum_count++;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((rx_valid && rx_ready) || (res_valid && res_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WatchdogLimit) begin
			$display("%0t: no beat for %0d cycles", $time, WatchdogLimit);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int            pick;
		logic [7:0]    ftype;
		logic [7:0]    db;
		logic [7:0]    ck;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		rx_valid  = 1'b0;
		rx_byte   = '0;
		for (int i = 0; i < 8; i++)
			frame_data[i] = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				1: begin
					write_gain(REG_ACCEL_GAIN, '1);
					write_gain(REG_RATE_GAIN, '1);
					write_gain(REG_ANGLE_GAIN, '1);
					write_gain(RegSpare, '1);
				end
				2: begin
					write_gain(REG_ACCEL_GAIN, '0);
					write_gain(REG_RATE_GAIN, '0);
					write_gain(REG_ANGLE_GAIN, '0);
					write_gain(RegSpare, '0);
				end
				3, 5: begin
					write_gain(REG_ACCEL_GAIN, GainWidth'($urandom_range(20'hFFFFF)));
					write_gain(REG_RATE_GAIN, GainWidth'($urandom_range(20'hFFFFF)));
					write_gain(REG_ANGLE_GAIN, GainWidth'($urandom_range(20'hFFFFF)));
				end
				4: begin
					write_gain(REG_ACCEL_GAIN, 20'd1);
					write_gain(REG_RATE_GAIN, RateGainRst);
					write_gain(REG_ANGLE_GAIN, 20'h80000);
				end
				default: ;
			endcase
			@(negedge clk);
			cfg_we <= 1'b0;
			case (phase / 2)
				0: begin
					send_idle = 33;
					recv_idle = 54;
				end
				1: begin
					send_idle = 54;
					recv_idle = 33;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase

			while (rx_beats < DirRows + (phase + 1) * PhaseBeats) begin
				pick = $urandom_range(99);
				if (pick < 72) begin
					ftype = TypeLo + 8'($urandom_range(3));
					ck = HdrByte + ftype;
					send_byte(HdrByte, 1'b0, NoResult);
					send_byte(ftype, 1'b0, NoResult);
					for (int k = 0; k < 8; k++) begin
						case ($urandom_range(7))
							0:       db = 8'h00;
							1:       db = 8'hFF;
							2:       db = 8'h80;
							3:       db = 8'h7F;
							default: db = 8'($urandom_range(255));
						endcase
						ck += db;
						send_byte(db, 1'b0, NoResult);
					end
					if ($urandom_range(99) < 12)
						ck += 8'($urandom_range(1, 255));
					send_byte(ck, 1'b0, NoResult);
				end else if (pick < 84) begin
					send_byte(HdrByte, 1'b0, NoResult);
					do db = 8'($urandom_range(255)); while (db >= TypeLo && db <= TypeHi);
					send_byte(db, 1'b0, NoResult);
				end else begin
					repeat ($urandom_range(1, 3))
						send_byte(8'($urandom_range(255)), 1'b0, NoResult);
				end
				if ($urandom_range(59) == 0)
					settle();
			end
		end

		settle();
		repeat (4) @(posedge clk);
		$display("Sent %0d byte beats across six gain settings and three idling patterns.",
			rx_beats);
		$display("Results: %0d good frames, %0d bad type bytes, %0d checksum mismatches.",
			ok_frames, bad_type_count, bad_sum_count);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- imu_frame_deframer_scaler_top.f -----
+incdir+sv
sv/imu_fds_pkg.sv
sv/imu_frame_deframer_scaler_top.sv
verif/testbench.sv
